### hdl/bee_pkg.sv
package bee_pkg;

    localparam int BYTE_W      = 8;
    localparam int FIELD_W     = 48;
    localparam int ONES_W      = $clog2(BYTE_W + 1);
    localparam int NUM_SLOTS   = BYTE_W + 2;
    localparam int FLUSH_SLOT  = BYTE_W;
    localparam int TOTAL_SLOT  = BYTE_W + 1;
    localparam int OUT_BITS    = 3 * FIELD_W + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

    localparam logic KIND_EXTENT = 1'b0;
    localparam logic KIND_TOTAL  = 1'b1;

    localparam logic [FIELD_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic               kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
        logic [FIELD_W-1:0] used;
        logic               ovf;
    } t_result;

endpackage

### hdl/bitmap_extent_extractor_top.sv
// Bitmap extent extractor.
// Slave stream: one bitmap byte per request in i_s_axis_tdata[7:0], bit 0 is the
// lowest cluster; i_s_axis_tlast marks the final byte of the map.
// Master stream: one result per request. tuser is the item kind (0 extent,
// 1 end-of-map total), tlast flags the last result caused by one input byte.
// A byte that closes no run and is not final yields no result.
// The first result of a byte passes through the slot register, then the
// output register. Throughput: a byte is taken every cycle while each byte
// yields at most one result and the receiver does not stall; a byte yielding
// k results (up to 6) holds the input while the single output register
// drains one result slot per cycle, as long as the receiver takes them.
// The final byte also clears position, run and count state for the next map.
// Reset (synchronous, active low) clears the slot valid bits and the scan state and drops o_m_axis_tvalid.
// When the receiver stalls, the output register holds its result and the
// slot register keeps the rest; one more byte is taken only once the slot
// register is empty or about to empty.
module bitmap_extent_extractor_top #(
    parameter int CLUSTER_BITS = 48
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [7:0] map_byte
    input  logic [bee_pkg::BYTE_W-1:0]         i_s_axis_tdata,
    // final_byte
    input  logic                               i_s_axis_tlast,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [47:0] extent_start, [95:48] extent_length, [143:96] used_total,
    // [144] overflow, [151:145] zero
    output logic [bee_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // item_kind
    output logic                               o_m_axis_tuser,
    // last_of_run
    output logic                               o_m_axis_tlast
);
    import bee_pkg::*;

    t_result                scan_slot [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   scan_vld;

    t_result                r_slot [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   r_slot_vld;
    t_result                r_out;
    logic                   r_out_vld;
    logic                   r_out_last;

    t_result                sel;
    logic [NUM_SLOTS-1:0]   rem;
    logic                   move;
    logic                   load;

    bee_scan #(
        .CLUSTER_BITS (CLUSTER_BITS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_bits     (i_s_axis_tdata),
        .i_fin      (i_s_axis_tlast),
        .o_slot     (scan_slot),
        .o_slot_vld (scan_vld)
    );

    // lowest pending slot goes out first
    always_comb begin
        sel = r_slot[0];
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_slot_vld[i]) begin
                sel = r_slot[i];
            end
        end
    end

    assign rem             = r_slot_vld & (r_slot_vld - NUM_SLOTS'(1));
    assign move            = (r_slot_vld != '0) && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = (r_slot_vld == '0) || (move && (rem == '0));
    assign load            = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (load) begin
                r_slot_vld <= scan_vld;
            end else if (move) begin
                r_slot_vld <= rem;
            end
            if (move) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_slot <= scan_slot;
        end
        if (move) begin
            r_out      <= sel;
            r_out_last <= (rem == '0);
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out.ovf, r_out.used,
                              r_out.length, r_out.start};
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out_last;

endmodule

### hdl/bee_scan.sv
module bee_scan #(
    parameter int CLUSTER_BITS = 48
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  logic [bee_pkg::BYTE_W-1:0]      i_bits,
    input  logic                            i_fin,
    output bee_pkg::t_result                o_slot [bee_pkg::NUM_SLOTS],
    output logic [bee_pkg::NUM_SLOTS-1:0]   o_slot_vld
);
    import bee_pkg::*;

    localparam logic [CLUSTER_BITS-1:0] POS_MAX = '1;

    logic                    r_run_open;
    logic [CLUSTER_BITS-1:0] r_run_start;
    logic [CLUSTER_BITS-1:0] r_pos;
    logic [FIELD_W-1:0]      r_cnt;
    logic                    r_sat;

    // per-bit views: index b is the state seen just before bit b
    logic [CLUSTER_BITS-1:0] pos     [BYTE_W+1];
    logic [CLUSTER_BITS-1:0] st      [BYTE_W+1];
    logic [FIELD_W-1:0]      cnt     [BYTE_W+1];
    logic                    sat_at  [BYTE_W+1];
    logic                    open_at [BYTE_W+1];

    function automatic logic [FIELD_W-1:0] to_field(input logic [CLUSTER_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[FIELD_W-1:0];
    endfunction

    always_comb begin
        logic [CLUSTER_BITS:0] psum;
        logic [FIELD_W:0]      csum;
        logic [ONES_W-1:0]     ones;
        ones = '0;
        for (int b = 0; b <= BYTE_W; b++) begin
            psum   = {1'b0, r_pos} + (CLUSTER_BITS+1)'(b);
            pos[b] = (psum > {1'b0, POS_MAX}) ? POS_MAX : psum[CLUSTER_BITS-1:0];
            csum   = {1'b0, r_cnt} + (FIELD_W+1)'(ones);
            cnt[b] = (csum > {1'b0, CNT_MAX}) ? CNT_MAX : csum[FIELD_W-1:0];
            if (b < BYTE_W) begin
                ones = ones + ONES_W'(i_bits[b]);
            end
        end
    end

    always_comb begin
        sat_at[0]  = r_sat;
        open_at[0] = r_run_open;
        st[0]      = r_run_start;
        for (int b = 1; b <= BYTE_W; b++) begin
            // flag sets once a bit has been taken at the top position
            sat_at[b]  = r_sat | (pos[b-1] == POS_MAX);
            open_at[b] = i_bits[b-1];
            st[b]      = (i_bits[b-1] && !open_at[b-1]) ? pos[b-1] : st[b-1];
        end
    end

    always_comb begin
        for (int b = 0; b < BYTE_W; b++) begin
            o_slot_vld[b]    = !i_bits[b] && open_at[b];
            o_slot[b].kind   = KIND_EXTENT;
            o_slot[b].start  = to_field(st[b]);
            o_slot[b].length = to_field(pos[b] - st[b]);
            o_slot[b].used   = cnt[b];
            o_slot[b].ovf    = sat_at[b];
        end
        o_slot_vld[FLUSH_SLOT]    = i_fin && open_at[BYTE_W];
        o_slot[FLUSH_SLOT].kind   = KIND_EXTENT;
        o_slot[FLUSH_SLOT].start  = to_field(st[BYTE_W]);
        o_slot[FLUSH_SLOT].length = to_field(pos[BYTE_W] - st[BYTE_W]);
        o_slot[FLUSH_SLOT].used   = cnt[BYTE_W];
        o_slot[FLUSH_SLOT].ovf    = sat_at[BYTE_W];
        o_slot_vld[TOTAL_SLOT]    = i_fin;
        o_slot[TOTAL_SLOT].kind   = KIND_TOTAL;
        o_slot[TOTAL_SLOT].start  = '0;
        o_slot[TOTAL_SLOT].length = '0;
        o_slot[TOTAL_SLOT].used   = cnt[BYTE_W];
        o_slot[TOTAL_SLOT].ovf    = sat_at[BYTE_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_open  <= 1'b0;
            r_run_start <= '0;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_sat       <= 1'b0;
        end else if (i_load) begin
            if (i_fin) begin
                r_run_open  <= 1'b0;
                r_run_start <= '0;
                r_pos       <= '0;
                r_cnt       <= '0;
                r_sat       <= 1'b0;
            end else begin
                r_run_open  <= open_at[BYTE_W];
                r_run_start <= st[BYTE_W];
                r_pos       <= pos[BYTE_W];
                r_cnt       <= cnt[BYTE_W];
                r_sat       <= sat_at[BYTE_W];
            end
        end
    end

endmodule

### hdl/bee_checker.sv
module bee_port_assert (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic [bee_pkg::BYTE_W-1:0]       i_s_axis_tdata,
    input logic                             i_s_axis_tlast,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [bee_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input logic                             o_m_axis_tuser,
    input logic                             o_m_axis_tlast
);
    import bee_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
             && $stable(o_m_axis_tlast)))
        else $error("master result changed while stalled");

    // total item ends the results of its byte
    a_total_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == KIND_TOTAL) |-> o_m_axis_tlast)
        else $error("total item without tlast");

    a_total_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == KIND_TOTAL) |->
            (o_m_axis_tdata[2*FIELD_W-1:0] == '0))
        else $error("total item carries start or length");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_axis_tvalid))
        else $error("result valid right after reset");

endmodule

bind bitmap_extent_extractor_top bee_port_assert u_bee_checker (.*);

### tb/bee_checker.sv
module bee_checker
    import bee_pkg::*;
#(
    parameter int CLUSTER_BITS = 48
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    // [7:0] map_byte
    input  logic [BYTE_W-1:0]      i_s_tdata,
    // final_byte
    input  logic                   i_s_tlast,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    // [47:0] extent_start, [95:48] extent_length, [143:96] used_total,
    // [144] overflow, [151:145] zero
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    // item_kind
    input  logic                   i_m_tuser,
    // last_of_run
    input  logic                   i_m_tlast,
    output int                     o_errors,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_result res;
        logic    last;
    } t_extent_item;

    localparam logic [63:0] POS_MAX = (CLUSTER_BITS >= 64) ? '1 :
                                      ((64'd1 << CLUSTER_BITS) - 64'd1);

    logic               run_open;
    logic [63:0]        run_start;
    logic [63:0]        cluster_pos;
    logic [FIELD_W-1:0] used_count;
    logic               pos_sat;

    t_extent_item extents_due[$];
    t_extent_item head_item;
    int           mismatch_count = 0;
    int           due_count = 0;

    assign o_errors  = mismatch_count;
    assign o_pending = due_count;

    task automatic clear_map_state();
        run_open    = 1'b0;
        run_start   = '0;
        cluster_pos = '0;
        used_count  = '0;
        pos_sat     = 1'b0;
    endtask

    function automatic t_extent_item make_item(input logic kind, input logic [63:0] start,
                                               input logic [63:0] len);
        t_extent_item it;
        it.res.kind   = kind;
        it.res.start  = start[FIELD_W-1:0];
        it.res.length = len[FIELD_W-1:0];
        it.res.used   = used_count;
        it.res.ovf    = pos_sat;
        it.last       = 1'b0;
        return it;
    endfunction

    // Walks a byte LSB first; queues closed extents, plus total if final.
    task automatic walk_map_byte(input logic [BYTE_W-1:0] map_byte, input logic final_byte);
        t_extent_item batch [6];
        int           n;
        n = 0;
        for (int b = 0; b < BYTE_W; b++) begin
            if (map_byte[b]) begin
                if (used_count != CNT_MAX) used_count++;
                if (!run_open) begin
                    run_open  = 1'b1;
                    run_start = cluster_pos;
                end
            end else if (run_open) begin
                batch[n] = make_item(KIND_EXTENT, run_start, cluster_pos - run_start);
                n++;
                run_open = 1'b0;
            end
            // position sticks at its top value once reached
            if (cluster_pos >= POS_MAX) begin
                cluster_pos = POS_MAX;
                pos_sat     = 1'b1;
            end else begin
                cluster_pos++;
            end
        end
        if (final_byte) begin
            if (run_open) begin
                batch[n] = make_item(KIND_EXTENT, run_start, cluster_pos - run_start);
                n++;
            end
            batch[n] = make_item(KIND_TOTAL, '0, '0);
            n++;
            clear_map_state();
        end
        if (n > 0) batch[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) extents_due.push_back(batch[k]);
    endtask

    task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                               input logic [FIELD_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            extents_due.delete();
            clear_map_state();
        end else begin
            // results of a byte never leave on the edge that takes it
            if (i_m_tvalid && i_m_tready) begin
                if (extents_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual tdata %0h tuser %0b",
                             $time, i_m_tdata, i_m_tuser);
                    mismatch_count++;
                end else begin
                    head_item = extents_due.pop_front();
                    check_field("item_kind", FIELD_W'(head_item.res.kind), FIELD_W'(i_m_tuser));
                    check_field("extent_start", head_item.res.start, i_m_tdata[FIELD_W-1:0]);
                    check_field("extent_length", head_item.res.length,
                                i_m_tdata[2*FIELD_W-1:FIELD_W]);
                    check_field("used_total", head_item.res.used,
                                i_m_tdata[3*FIELD_W-1:2*FIELD_W]);
                    check_field("overflow", FIELD_W'(head_item.res.ovf),
                                FIELD_W'(i_m_tdata[3*FIELD_W]));
                    check_field("tdata padding", '0, FIELD_W'(i_m_tdata >> OUT_BITS));
                    check_field("last_of_run", FIELD_W'(head_item.last), FIELD_W'(i_m_tlast));
                end
            end
            if (i_s_tvalid && i_s_tready) walk_map_byte(i_s_tdata, i_s_tlast);
        end
        due_count <= extents_due.size();
    end

endmodule

### tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bee_pkg::*;

    // narrow position width so the parameter is carried below the field width
    localparam int CLUSTER_BITS  = 16;
    localparam int RANDOM_BYTES  = 93;

    logic                   clk;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    int err_count;
    int pending_count;
    bit idle_on = 1'b1;

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    bitmap_extent_extractor_top #(
        .CLUSTER_BITS(CLUSTER_BITS)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    bee_checker #(
        .CLUSTER_BITS(CLUSTER_BITS)
    ) u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .i_m_tlast  (m_tlast),
        .o_errors   (err_count),
        .o_pending  (pending_count)
    );

    always @(posedge clk) begin
        m_tready <= !idle_on || ($urandom_range(99) >= 31);
    end

    // Returns on the edge that takes the request; valid stays up for the next one.
    task automatic send_map_byte(input logic [BYTE_W-1:0] map_byte, input logic final_byte);
        while (idle_on && $urandom_range(99) < 31) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= map_byte;
        s_tlast  <= final_byte;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] pick_map_byte();
        case ($urandom_range(5))
            0:       return 8'h00;
            1:       return 8'hFF;
            4:       return 8'h01 << $urandom_range(7);
            5:       return ~(8'h01 << $urandom_range(7));
            default: return BYTE_W'($urandom_range(255));
        endcase
    endfunction

    initial begin : stimulus
        int                sent;
        int                map_len;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_map_byte(8'h00, 1'b0);
        send_map_byte(8'hFF, 1'b0);
        send_map_byte(8'hFF, 1'b0);
        send_map_byte(8'h00, 1'b0);
        send_map_byte(8'h55, 1'b0);
        send_map_byte(8'hAA, 1'b0);
        // run carried in, three inner runs, open run flushed, then total
        send_map_byte(8'hAA, 1'b1);
        send_map_byte(8'h00, 1'b1);
        send_map_byte(8'hFF, 1'b1);
        send_map_byte(8'h80, 1'b0);
        send_map_byte(8'h01, 1'b0);
        send_map_byte(8'h7F, 1'b0);
        send_map_byte(8'hFE, 1'b1);
        send_map_byte(8'h01, 1'b1);
        send_map_byte(8'h80, 1'b1);
        send_map_byte(8'hF0, 1'b0);
        send_map_byte(8'h0F, 1'b1);

        sent = 0;
        while (sent < RANDOM_BYTES) begin
            map_len = $urandom_range(1, 12);
            for (int k = 0; k < map_len; k++) begin
                idle_on = !(sent >= 40 && sent < 75);
                send_map_byte(pick_map_byte(), k == map_len - 1);
                sent++;
            end
        end
        idle_on = 1'b1;
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_count == 0 && pending_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
